FILE: design/gti_pkg.sv
// Shared types, codes and address helper for the 5-D grid table interpolator.
`timescale 1ns / 1ps
package gti_pkg;

    localparam int ADDR_W = 15;
    localparam int DATA_W = 32;
    localparam int CELL_W = 5;
    localparam int FRAC_W = 16;
    localparam int AXES = 4;
    localparam int LEVELS = 5;
    localparam int CFG_W = 64;
    localparam int CFG_IDX_W = 3;

    // request kinds
    localparam logic FUNC_WRITE = 1'b0;
    localparam logic FUNC_QUERY = 1'b1;

    // result status codes
    typedef logic [1:0] status_t;
    localparam status_t ST_OK      = 2'd0;
    localparam status_t ST_RANGE   = 2'd1;
    localparam status_t ST_BRACKET = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_X_WIN   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_Y_WIN   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SX_WIN  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SY_WIN  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_X_INV   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_Y_INV   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_SX_INV  = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_SY_INV  = 3'd7;

    typedef enum logic [3:0] {
        S_IDLE,
        S_AXIS_MUL,
        S_AXIS_CHK,
        S_WALK_RD,
        S_WALK_CHK,
        S_DIV,
        S_CORNER_RD,
        S_CORNER_WAIT,
        S_MERGE
    } state_t;

    // flat table index, angle fastest, wrapped to the store depth
    function automatic logic [ADDR_W-1:0] flat_index(
        input int ix, input int iy, input int idx, input int idy, input int ia,
        input int gy, input int gsx, input int gsy, input int ga);
        int k;
        k = ((((ix * gy + iy) * gsx + idx) * gsy + idy) * ga) + ia;
        return k[ADDR_W-1:0];
    endfunction

endpackage

FILE: design/gti_ram.sv
// Single-port-write, single-port-read synchronous RAM with registered read data.
`timescale 1ns / 1ps
module gti_ram #(
    parameter int WIDTH = 32,
    parameter int AW = 15
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);
    logic [WIDTH-1:0] mem [2**AW];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // read port, registered read data
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end
endmodule

FILE: design/gti_lerp.sv
// One rounded linear blend: a + round((b - a) * f / 65536), f in Q0.16.
`timescale 1ns / 1ps
module gti_lerp (
    input  logic signed [gti_pkg::DATA_W-1:0] a,
    input  logic signed [gti_pkg::DATA_W-1:0] b,
    input  logic        [gti_pkg::FRAC_W-1:0] f,
    output logic signed [gti_pkg::DATA_W-1:0] y
);
    import gti_pkg::*;

    logic signed [DATA_W:0]            diff;
    logic signed [FRAC_W:0]            fs;
    logic signed [DATA_W+FRAC_W+1:0]   prod;
    logic signed [DATA_W+FRAC_W+1:0]   sum;

    // a*(1-f) + b*f folds to a + (b-a)*f, exact since a*65536 has no fraction
    assign diff = {b[DATA_W-1], b} - {a[DATA_W-1], a};
    assign fs   = $signed({1'b0, f});
    assign prod = diff * fs;
    assign sum  = prod + (DATA_W+FRAC_W+2)'(32768);
    assign y    = a + sum[DATA_W+FRAC_W-1:FRAC_W];
endmodule

FILE: design/gti_div.sv
// Iterative restoring divider for the angle fraction, one quotient bit per cycle.
`timescale 1ns / 1ps
module gti_div (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [gti_pkg::DATA_W-1:0]    num,
    input  logic [gti_pkg::DATA_W-1:0]    den,
    output logic [gti_pkg::FRAC_W-1:0]    quotient,
    output logic                          done
);
    import gti_pkg::*;

    localparam int CNT_W = $clog2(FRAC_W + 1);

    logic                run_reg, run_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic                done_reg, done_next;
    logic [DATA_W:0]     rem_reg, rem_next;
    logic [DATA_W-1:0]   den_reg, den_next;
    logic [FRAC_W-1:0]   quo_reg, quo_next;
    logic [DATA_W:0]     shifted;

    assign shifted = {rem_reg[DATA_W-1:0], 1'b0};

    // numerator below divisor, so quotient fits FRAC_W bits
    always_comb
    begin
        run_next  = run_reg;
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        rem_next  = rem_reg;
        den_next  = den_reg;
        quo_next  = quo_reg;
        if (start)
        begin
            run_next = 1'b1;
            cnt_next = '0;
            rem_next = {1'b0, num};
            den_next = den;
        end
        else if (run_reg)
        begin
            if (shifted >= {1'b0, den_reg})
            begin
                rem_next = shifted - {1'b0, den_reg};
                quo_next = {quo_reg[FRAC_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = shifted;
                quo_next = {quo_reg[FRAC_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(FRAC_W - 1))
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            run_reg  <= run_next;
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        den_reg <= den_next;
        quo_reg <= quo_next;
    end

    assign quotient = quo_reg;
    assign done     = done_reg;
endmodule

FILE: design/grid_table_interpolator_5d.sv
// Top level: 5-D grid table store and multilinear interpolation sequencer.
// Write request: result in the cycle after acceptance; busy stays low.
// Query: axis cuts (multiply, then check) for each of the four axes, a walk of the angle column
//   with a read and a check per entry walked, the divider, then 32 corner reads and merge steps
//   through one shared blend unit pair.
// One request at a time; the result strobe lasts one cycle and cannot be stalled.
// Reset clears control state and configuration; table contents are undefined until written.
`timescale 1ns / 1ps
module grid_table_interpolator_5d #(
    parameter int GRID_X = 8,
    parameter int GRID_Y = 8,
    parameter int GRID_SLOPE_X = 8,
    parameter int GRID_SLOPE_Y = 8,
    parameter int GRID_ANGLE = 8
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 start,
    output logic                                 busy,
    input  logic                                 func,
    input  logic        [gti_pkg::ADDR_W-1:0]    entry_index,
    input  logic signed [gti_pkg::DATA_W-1:0]    entry_angle,
    input  logic signed [gti_pkg::DATA_W-1:0]    entry_momentum,
    input  logic signed [gti_pkg::DATA_W-1:0]    entry_path,
    input  logic signed [gti_pkg::DATA_W-1:0]    pos_x,
    input  logic signed [gti_pkg::DATA_W-1:0]    pos_y,
    input  logic signed [gti_pkg::DATA_W-1:0]    slope_x,
    input  logic signed [gti_pkg::DATA_W-1:0]    slope_y,
    input  logic signed [gti_pkg::DATA_W-1:0]    query_angle,
    output logic                                 done,
    output gti_pkg::status_t                     status,
    output logic signed [gti_pkg::DATA_W-1:0]    momentum,
    output logic signed [gti_pkg::DATA_W-1:0]    path_length,
    input  logic                                 cfg_write,
    input  logic        [gti_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic        [gti_pkg::CFG_W-1:0]     cfg_data
);
    import gti_pkg::*;

    localparam int LVL_W = $clog2(LEVELS + 1);

    // control and configuration
    state_t                 state_reg, state_next;
    logic [1:0]             ax_reg, ax_next;
    logic [CELL_W-1:0]      idx_reg, idx_next;
    logic [4:0]             k_reg, k_next;
    logic [LVL_W-1:0]       lvl_reg, lvl_next;
    logic [LEVELS-1:0]      hvld_reg, hvld_next;
    logic                   done_reg, done_next;
    logic [CFG_W-1:0]       win_reg [AXES];
    logic [DATA_W-1:0]      inv_reg [AXES];

    // datapath
    logic signed [DATA_W-1:0] pos_reg [AXES], pos_next [AXES];
    logic signed [DATA_W-1:0] q_reg, q_next;
    logic [2*DATA_W-1:0]      prod_reg, prod_next;
    logic                     inwin_reg, inwin_next;
    logic [CELL_W-1:0]        cell_reg [AXES], cell_next [AXES];
    logic [FRAC_W-1:0]        frac_reg [AXES], frac_next [AXES];
    logic signed [DATA_W-1:0] prev_reg, prev_next;
    logic [FRAC_W-1:0]        fa_reg, fa_next;
    logic signed [DATA_W-1:0] cm_reg, cm_next, cp_reg, cp_next;
    logic signed [DATA_W-1:0] hm_reg [LEVELS], hm_next [LEVELS];
    logic signed [DATA_W-1:0] hp_reg [LEVELS], hp_next [LEVELS];
    status_t                  status_reg, status_next;
    logic signed [DATA_W-1:0] mom_reg, mom_next, path_reg, path_next;

    logic                     accept;
    logic                     mem_we;
    logic [ADDR_W-1:0]        raddr;
    logic [DATA_W-1:0]        angle_rdata;
    logic [2*DATA_W-1:0]      mp_rdata;

    logic signed [DATA_W-1:0] lo_sel, hi_sel, pos_sel;
    logic [DATA_W-1:0]        inv_sel;
    logic signed [DATA_W:0]   diff_sel;
    logic [DATA_W-1:0]        grid_sel;
    logic signed [DATA_W-1:0] angle_rd;
    logic                     corner_fail;
    logic                     div_start, div_done;
    logic [DATA_W-1:0]        div_num, div_den;
    logic [FRAC_W-1:0]        div_q;
    logic [FRAC_W-1:0]        fs_sel;
    logic signed [DATA_W-1:0] lerp_m, lerp_p;

    assign accept = start && !busy;
    assign busy   = (state_reg != S_IDLE);
    assign mem_we = accept && (func == FUNC_WRITE);

    // table stores
    gti_ram #(.WIDTH(DATA_W), .AW(ADDR_W)) u_angle_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (entry_index),
        .wdata (entry_angle),
        .raddr (raddr),
        .rdata (angle_rdata)
    );

    gti_ram #(.WIDTH(2*DATA_W), .AW(ADDR_W)) u_mp_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (entry_index),
        .wdata ({entry_momentum, entry_path}),
        .raddr (raddr),
        .rdata (mp_rdata)
    );

    // angle fraction divider
    gti_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .num      (div_num),
        .den      (div_den),
        .quotient (div_q),
        .done     (div_done)
    );

    // blend units, one per value
    gti_lerp u_lerp_m (.a(hm_reg[lvl_reg[2:0]]), .b(cm_reg), .f(fs_sel), .y(lerp_m));
    gti_lerp u_lerp_p (.a(hp_reg[lvl_reg[2:0]]), .b(cp_reg), .f(fs_sel), .y(lerp_p));

    // blend order: dy, y, dx, x, angle
    always_comb
    begin
        case (lvl_reg)
            LVL_W'(0): fs_sel = frac_reg[3];
            LVL_W'(1): fs_sel = frac_reg[1];
            LVL_W'(2): fs_sel = frac_reg[2];
            LVL_W'(3): fs_sel = frac_reg[0];
            default:   fs_sel = fa_reg;
        endcase
    end

    // per-axis operand selection
    always_comb
    begin
        lo_sel  = signed'(win_reg[ax_reg][DATA_W-1:0]);
        hi_sel  = signed'(win_reg[ax_reg][CFG_W-1:DATA_W]);
        pos_sel = pos_reg[ax_reg];
        inv_sel = inv_reg[ax_reg];
        diff_sel = {pos_sel[DATA_W-1], pos_sel} - {lo_sel[DATA_W-1], lo_sel};
        case (ax_reg)
            2'd0:    grid_sel = DATA_W'(GRID_X);
            2'd1:    grid_sel = DATA_W'(GRID_Y);
            2'd2:    grid_sel = DATA_W'(GRID_SLOPE_X);
            default: grid_sel = DATA_W'(GRID_SLOPE_Y);
        endcase
    end

    assign angle_rd = signed'(angle_rdata);
    assign corner_fail = (int'(cell_reg[0]) + 1 >= GRID_X) ||
                         (int'(cell_reg[1]) + 1 >= GRID_Y) ||
                         (int'(cell_reg[2]) + 1 >= GRID_SLOPE_X) ||
                         (int'(cell_reg[3]) + 1 >= GRID_SLOPE_Y);
    assign div_num = DATA_W'(prev_reg - q_reg);
    assign div_den = DATA_W'(prev_reg - angle_rd);

    // read address: angle column walk or corner fetch
    always_comb
    begin
        if (state_reg == S_CORNER_RD)
        begin
            raddr = flat_index(int'(cell_reg[0]) + int'(k_reg[3]),
                               int'(cell_reg[1]) + int'(k_reg[1]),
                               int'(cell_reg[2]) + int'(k_reg[2]),
                               int'(cell_reg[3]) + int'(k_reg[0]),
                               int'(idx_reg) + int'(k_reg[4]),
                               GRID_Y, GRID_SLOPE_X, GRID_SLOPE_Y, GRID_ANGLE);
        end
        else
        begin
            raddr = flat_index(int'(cell_reg[0]), int'(cell_reg[1]),
                               int'(cell_reg[2]), int'(cell_reg[3]), int'(idx_reg),
                               GRID_Y, GRID_SLOPE_X, GRID_SLOPE_Y, GRID_ANGLE);
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept && func == FUNC_QUERY)
                begin
                    state_next = S_AXIS_MUL;
                end
            end
            S_AXIS_MUL:
            begin
                state_next = S_AXIS_CHK;
            end
            S_AXIS_CHK:
            begin
                if (!inwin_reg || prod_reg[2*DATA_W-1:DATA_W] >= grid_sel)
                begin
                    state_next = S_IDLE;
                end
                else if (ax_reg == 2'd3)
                begin
                    state_next = S_WALK_RD;
                end
                else
                begin
                    state_next = S_AXIS_MUL;
                end
            end
            S_WALK_RD:
            begin
                state_next = S_WALK_CHK;
            end
            S_WALK_CHK:
            begin
                if (angle_rd < q_reg)
                begin
                    if (idx_reg == '0 || corner_fail)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        state_next = S_DIV;
                    end
                end
                else if (idx_reg == CELL_W'(GRID_ANGLE - 1))
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    state_next = S_WALK_RD;
                end
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    state_next = S_CORNER_RD;
                end
            end
            S_CORNER_RD:
            begin
                state_next = S_CORNER_WAIT;
            end
            S_CORNER_WAIT:
            begin
                state_next = S_MERGE;
            end
            S_MERGE:
            begin
                if (lvl_reg == LVL_W'(LEVELS))
                begin
                    state_next = S_IDLE;
                end
                else if (!hvld_reg[lvl_reg[2:0]])
                begin
                    state_next = S_CORNER_RD;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // datapath and result updates
    always_comb
    begin
        ax_next     = ax_reg;
        idx_next    = idx_reg;
        k_next      = k_reg;
        lvl_next    = lvl_reg;
        hvld_next   = hvld_reg;
        done_next   = 1'b0;
        pos_next    = pos_reg;
        q_next      = q_reg;
        prod_next   = prod_reg;
        inwin_next  = inwin_reg;
        cell_next   = cell_reg;
        frac_next   = frac_reg;
        prev_next   = prev_reg;
        fa_next     = fa_reg;
        cm_next     = cm_reg;
        cp_next     = cp_reg;
        hm_next     = hm_reg;
        hp_next     = hp_reg;
        status_next = status_reg;
        mom_next    = mom_reg;
        path_next   = path_reg;
        div_start   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    pos_next[0] = pos_x;
                    pos_next[1] = pos_y;
                    pos_next[2] = slope_x;
                    pos_next[3] = slope_y;
                    q_next      = query_angle;
                    ax_next     = 2'd0;
                    if (func == FUNC_WRITE)
                    begin
                        done_next   = 1'b1;
                        status_next = ST_OK;
                        mom_next    = '0;
                        path_next   = '0;
                    end
                end
            end
            S_AXIS_MUL:
            begin
                inwin_next = (pos_sel >= lo_sel) && (pos_sel <= hi_sel);
                prod_next  = (2*DATA_W)'(diff_sel[DATA_W-1:0]) * (2*DATA_W)'(inv_sel);
            end
            S_AXIS_CHK:
            begin
                if (!inwin_reg || prod_reg[2*DATA_W-1:DATA_W] >= grid_sel)
                begin
                    done_next   = 1'b1;
                    status_next = ST_RANGE;
                    mom_next    = '0;
                    path_next   = '0;
                end
                else
                begin
                    cell_next[ax_reg] = prod_reg[DATA_W +: CELL_W];
                    frac_next[ax_reg] = prod_reg[FRAC_W +: FRAC_W];
                    ax_next  = ax_reg + 2'd1;
                    idx_next = '0;
                end
            end
            S_WALK_CHK:
            begin
                if (angle_rd < q_reg)
                begin
                    if (idx_reg == '0)
                    begin
                        done_next   = 1'b1;
                        status_next = ST_BRACKET;
                        mom_next    = '0;
                        path_next   = '0;
                    end
                    else if (corner_fail)
                    begin
                        done_next   = 1'b1;
                        status_next = ST_RANGE;
                        mom_next    = '0;
                        path_next   = '0;
                    end
                    else
                    begin
                        idx_next  = idx_reg - 1'b1;
                        div_start = 1'b1;
                    end
                end
                else if (idx_reg == CELL_W'(GRID_ANGLE - 1))
                begin
                    done_next   = 1'b1;
                    status_next = ST_BRACKET;
                    mom_next    = '0;
                    path_next   = '0;
                end
                else
                begin
                    prev_next = angle_rd;
                    idx_next  = idx_reg + 1'b1;
                end
            end
            S_DIV:
            begin
                fa_next   = div_q;
                k_next    = '0;
                lvl_next  = '0;
                hvld_next = '0;
            end
            S_CORNER_WAIT:
            begin
                cm_next  = signed'(mp_rdata[2*DATA_W-1:DATA_W]);
                cp_next  = signed'(mp_rdata[DATA_W-1:0]);
                lvl_next = '0;
            end
            S_MERGE:
            begin
                if (lvl_reg == LVL_W'(LEVELS))
                begin
                    done_next   = 1'b1;
                    status_next = ST_OK;
                    mom_next    = cm_reg;
                    path_next   = cp_reg;
                end
                else if (hvld_reg[lvl_reg[2:0]])
                begin
                    // pair complete: blend and carry up one level
                    cm_next = lerp_m;
                    cp_next = lerp_p;
                    hvld_next[lvl_reg[2:0]] = 1'b0;
                    lvl_next = lvl_reg + 1'b1;
                end
                else
                begin
                    // first of a pair: park it and fetch the next corner
                    hm_next[lvl_reg[2:0]]   = cm_reg;
                    hp_next[lvl_reg[2:0]]   = cp_reg;
                    hvld_next[lvl_reg[2:0]] = 1'b1;
                    k_next = k_reg + 1'b1;
                end
            end
            default:
            begin
            end
        endcase
    end

    // control registers and configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            ax_reg    <= '0;
            idx_reg   <= '0;
            k_reg     <= '0;
            lvl_reg   <= '0;
            hvld_reg  <= '0;
            done_reg  <= 1'b0;
            for (int i = 0; i < AXES; i++)
            begin
                win_reg[i] <= '0;
                inv_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            ax_reg    <= ax_next;
            idx_reg   <= idx_next;
            k_reg     <= k_next;
            lvl_reg   <= lvl_next;
            hvld_reg  <= hvld_next;
            done_reg  <= done_next;
            if (cfg_write)
            begin
                case (cfg_index)
                    CFG_X_WIN:  win_reg[0] <= cfg_data;
                    CFG_Y_WIN:  win_reg[1] <= cfg_data;
                    CFG_SX_WIN: win_reg[2] <= cfg_data;
                    CFG_SY_WIN: win_reg[3] <= cfg_data;
                    CFG_X_INV:  inv_reg[0] <= cfg_data[DATA_W-1:0];
                    CFG_Y_INV:  inv_reg[1] <= cfg_data[DATA_W-1:0];
                    CFG_SX_INV: inv_reg[2] <= cfg_data[DATA_W-1:0];
                    CFG_SY_INV: inv_reg[3] <= cfg_data[DATA_W-1:0];
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        pos_reg    <= pos_next;
        q_reg      <= q_next;
        prod_reg   <= prod_next;
        inwin_reg  <= inwin_next;
        cell_reg   <= cell_next;
        frac_reg   <= frac_next;
        prev_reg   <= prev_next;
        fa_reg     <= fa_next;
        cm_reg     <= cm_next;
        cp_reg     <= cp_next;
        hm_reg     <= hm_next;
        hp_reg     <= hp_next;
        status_reg <= status_next;
        mom_reg    <= mom_next;
        path_reg   <= path_next;
    end

    assign done        = done_reg;
    assign status      = status_reg;
    assign momentum    = mom_reg;
    assign path_length = path_reg;

    // a result always lands with the sequencer back at rest
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result strobe while sequencer busy");

    // failures carry zero values
    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status != ST_OK) |-> (momentum == '0 && path_length == '0))
        else $error("nonzero value on failed request");

    // the sequencer only leaves rest on an accepted request
    a_busy_start: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(busy) |-> $past(start))
        else $error("busy without request");

    // merge level never passes the top of the blend tree
    a_lvl_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_MERGE) |-> (lvl_reg <= LVL_W'(LEVELS)))
        else $error("merge level out of range");
endmodule
